// ----- rtl/core/fal_pkg.sv -----
// Shared types, constants and hash helpers for the flow-affinity load balancer.
package fal_pkg;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // lookup3 start value for a four-word key: 0xdeadbeef + (4 << 2)
    localparam logic [31:0] HASH_INIT  = 32'hdeadbeff;
    localparam int          HASH_LINES = 13;

    // Remainder unit: hash bits consumed per cycle, steps per 32-bit hash
    localparam int REM_BITS  = 4;
    localparam int REM_STEPS = 32 / REM_BITS;

    localparam int          SESS_W   = 11;
    localparam logic [10:0] SESS_MAX = 11'd2047;
    localparam logic [6:0]  LOAD_SCALE = 7'd100;
    localparam int          LOAD_W   = 18;
    localparam int          DIV_BITS = 6;
    localparam int          DIV_STEPS = LOAD_W / DIV_BITS;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CFG_LB_MODE      = 8'd0;
    localparam logic [7:0] CFG_ENABLED_MASK = 8'd1;
    localparam logic [7:0] CFG_HEALTHY_MASK = 8'd2;
    localparam logic [7:0] CFG_WEIGHTS      = 8'd3;

    localparam logic [1:0] MODE_HASH     = 2'd0;
    localparam logic [1:0] MODE_RR       = 2'd1;
    localparam logic [1:0] MODE_LEAST    = 2'd2;
    localparam logic [1:0] MODE_WEIGHTED = 2'd3;

    localparam logic [1:0]  RST_LB_MODE = 2'd0;
    localparam logic [7:0]  RST_ENABLED = 8'd15;
    localparam logic [7:0]  RST_HEALTHY = 8'd15;
    localparam logic [63:0] RST_WEIGHTS = 64'd7234017283807667300;

    typedef struct packed {
        logic [1:0]  lb_mode;
        logic [7:0]  enabled_mask;
        logic [7:0]  healthy_mask;
        logic [63:0] interface_weights;
    } cfg_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } flow_key_t;

    typedef struct packed {
        logic      not_ipv4;
        logic [2:0] hash_pick;
        flow_key_t key;
    } job_t;

    typedef struct packed {
        logic      valid;
        logic [2:0] choice;
        flow_key_t key;
    } table_entry_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hash_state_t;

    function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned sh);
        return (x << sh) | (x >> (32 - sh));
    endfunction

    // One line of the lookup3 mix/final sequence.
    function automatic hash_state_t hash_line(hash_state_t s, logic [31:0] w3,
                                              logic [3:0] k);
        hash_state_t r;
        r = s;
        case (k)
            4'd0: begin r.a = (s.a - s.c) ^ rotl32(s.c, 4);  r.c = s.c + s.b; end
            4'd1: begin r.b = (s.b - s.a) ^ rotl32(s.a, 6);  r.a = s.a + s.c; end
            4'd2: begin r.c = (s.c - s.b) ^ rotl32(s.b, 8);  r.b = s.b + s.a; end
            4'd3: begin r.a = (s.a - s.c) ^ rotl32(s.c, 16); r.c = s.c + s.b; end
            4'd4: begin r.b = (s.b - s.a) ^ rotl32(s.a, 19); r.a = s.a + s.c; end
            4'd5: begin r.c = (s.c - s.b) ^ rotl32(s.b, 4);  r.b = s.b + s.a; end
            4'd6: begin r.a = s.a + w3; r.c = (s.c ^ s.b) - rotl32(s.b, 14); end
            4'd7: r.a = (s.a ^ s.c) - rotl32(s.c, 11);
            4'd8: r.b = (s.b ^ s.a) - rotl32(s.a, 25);
            4'd9: r.c = (s.c ^ s.b) - rotl32(s.b, 16);
            4'd10: r.a = (s.a ^ s.c) - rotl32(s.c, 4);
            4'd11: r.b = (s.b ^ s.a) - rotl32(s.a, 14);
            4'd12: r.c = (s.c ^ s.b) - rotl32(s.b, 24);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/fal_front.sv -----
// Front end: accept headers, build the key, hash it and reduce the hash.
module fal_front
    import fal_pkg::*;
#(
    parameter int INTERFACES    = 4,
    parameter int TABLE_ENTRIES = 1024,
    parameter int BUCKET_WAYS   = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             hold,
    input  cfg_t                             cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [103:0]                     s_tdata,
    input  logic [15:0]                      s_tuser,
    output logic                             push_valid,
    input  logic                             push_ready,
    output job_t                             push_job,
    output logic [$clog2(TABLE_ENTRIES)-1:0] push_base
);

    localparam int AW      = $clog2(TABLE_ENTRIES);
    localparam int BUCKETS = TABLE_ENTRIES / BUCKET_WAYS;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [BKT_W:0] BKT_DIV = (BKT_W + 1)'(BUCKETS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    hash_state_t      hs_reg, hs_next;
    logic [31:0]      w3_reg;
    logic [31:0]      hval_reg, hval_next;
    logic [3:0]       step_reg;
    logic [BKT_W-1:0] brem_reg, brem_next;
    logic [2:0]       nrem_reg, nrem_next;
    job_t             job_reg;
    flow_key_t        in_key;
    logic             in_l4;
    logic [3:0]       n_elig;
    logic             accept;

    assign s_tready   = (state_reg == F_IDLE) && !hold;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_job   = job_reg;
    assign push_base  = AW'(brem_reg * BUCKET_WAYS);

    always_comb begin
        in_l4 = (s_tdata[71:64] == PROTO_TCP) || (s_tdata[71:64] == PROTO_UDP);
        in_key.source_address      = s_tdata[31:0];
        in_key.destination_address = s_tdata[63:32];
        in_key.ip_protocol         = s_tdata[71:64];
        in_key.source_port         = in_l4 ? s_tdata[87:72] : 16'd0;
        in_key.destination_port    = in_l4 ? s_tdata[103:88] : 16'd0;
    end

    always_comb begin
        n_elig = 4'd0;
        for (int i = 0; i < INTERFACES; i++) begin
            n_elig = n_elig + 4'(cfg.enabled_mask[i] & cfg.healthy_mask[i]);
        end
    end

    assign hs_next = hash_line(hs_reg, w3_reg, step_reg);

    // Shift the hash in MSB first and keep both remainders.
    always_comb begin
        logic [BKT_W:0] bext;
        logic [3:0]     next_ext;
        logic [BKT_W-1:0] br;
        logic [2:0]     nr;
        logic [31:0]    hv;
        br = brem_reg;
        nr = nrem_reg;
        hv = hval_reg;
        for (int j = 0; j < REM_BITS; j++) begin
            bext = {br, hv[31]};
            if (bext >= BKT_DIV) begin
                bext = bext - BKT_DIV;
            end
            br = bext[BKT_W-1:0];
            next_ext = {nr, hv[31]};
            if (next_ext >= n_elig) begin
                next_ext = next_ext - n_elig;
            end
            nr = next_ext[2:0];
            hv = {hv[30:0], 1'b0};
        end
        brem_next = br;
        nrem_next = nr;
        hval_next = hv;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser != ETH_TYPE_IPV4) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                if (step_reg == 4'(HASH_LINES - 1)) begin
                    state_next = F_MOD;
                end
            end
            F_MOD: begin
                if (step_reg == 4'(REM_STEPS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    job_reg.not_ipv4  <= (s_tuser != ETH_TYPE_IPV4);
                    job_reg.hash_pick <= 3'd0;
                    job_reg.key       <= in_key;
                    hs_reg.a <= HASH_INIT + in_key.source_address;
                    hs_reg.b <= HASH_INIT + in_key.destination_address;
                    hs_reg.c <= HASH_INIT + {in_key.source_port, in_key.destination_port};
                    w3_reg   <= {24'd0, in_key.ip_protocol};
                    step_reg <= 4'd0;
                    brem_reg <= '0;
                end
            end
            F_HASH: begin
                hs_reg <= hs_next;
                if (step_reg == 4'(HASH_LINES - 1)) begin
                    hval_reg <= hs_next.c;
                    step_reg <= 4'd0;
                    brem_reg <= '0;
                    nrem_reg <= 3'd0;
                end else begin
                    step_reg <= step_reg + 4'd1;
                end
            end
            F_MOD: begin
                brem_reg <= brem_next;
                nrem_reg <= nrem_next;
                hval_reg <= hval_next;
                step_reg <= step_reg + 4'd1;
                job_reg.hash_pick <= nrem_next;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/fal_fifo.sv -----
// Short request queue between the front and back ends.
module fal_fifo
    import fal_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/fal_back.sv -----
// Back end: session table lookup, interface choice, insert and result register.
module fal_back
    import fal_pkg::*;
#(
    parameter int INTERFACES    = 4,
    parameter int TABLE_ENTRIES = 1024,
    parameter int BUCKET_WAYS   = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cfg_t                             cfg,
    output logic                             clearing,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  job_t                             pop_job,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] pop_base,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,
    output logic [2:0]                       m_tuser
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int WCW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int IW  = $clog2(INTERFACES);

    localparam logic [3:0] B_CLR  = 4'd0;
    localparam logic [3:0] B_IDLE = 4'd1;
    localparam logic [3:0] B_RD   = 4'd2;
    localparam logic [3:0] B_CMP  = 4'd3;
    localparam logic [3:0] B_PICK = 4'd4;
    localparam logic [3:0] B_RR   = 4'd5;
    localparam logic [3:0] B_LOAD = 4'd6;
    localparam logic [3:0] B_DIV  = 4'd7;
    localparam logic [3:0] B_MIN  = 4'd8;
    localparam logic [3:0] B_INS  = 4'd9;
    localparam logic [3:0] B_DONE = 4'd10;

    table_entry_t flow_mem [TABLE_ENTRIES];
    table_entry_t rd_data_reg;
    table_entry_t wr_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;

    logic [3:0]        state_reg;
    logic [AW-1:0]     clr_addr_reg;
    job_t              job_reg;
    logic [AW-1:0]     base_reg;
    logic [WCW-1:0]    way_reg, free_way_reg;
    logic              free_found_reg;
    logic [2:0]        sel_reg;
    logic              new_reg, rec_reg, nip_reg;
    logic [31:0]       rr_pos_reg;
    logic [IW-1:0]     rr_idx_reg;
    logic [IW-1:0]     iface_reg, best_reg;
    logic              best_found_reg;
    logic [LOAD_W-1:0] min_reg, load_reg, quot_next;
    logic [7:0]        drem_reg, drem_next;
    logic [1:0]        dstep_reg;
    logic [SESS_W-1:0] sess_reg [INTERFACES];
    logic              m_tvalid_reg;
    logic [2:0]        m_egress_reg;
    logic [2:0]        m_flags_reg;

    logic [INTERFACES-1:0] elig;
    logic                  any_elig;
    logic [2:0]            hash_sel;
    logic [7:0]            weight;
    logic                  last_iface;
    logic                  out_free;
    logic                  key_hit;

    assign clearing  = (state_reg == B_CLR);
    assign pop_ready = (state_reg == B_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'd0, m_egress_reg};
    assign m_tuser   = m_flags_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < INTERFACES; i++) begin
            elig[i] = cfg.enabled_mask[i] & cfg.healthy_mask[i];
        end
    end
    assign any_elig = |elig;

    // Pick the hash_pick-th eligible interface counting up from zero.
    always_comb begin
        logic [3:0] cnt;
        logic       found;
        cnt      = 4'd0;
        found    = 1'b0;
        hash_sel = 3'd0;
        for (int i = 0; i < INTERFACES; i++) begin
            if (elig[i]) begin
                if (!found && cnt == {1'b0, job_reg.hash_pick}) begin
                    hash_sel = 3'(i);
                    found    = 1'b1;
                end
                cnt = cnt + 4'd1;
            end
        end
    end

    assign last_iface = (iface_reg == IW'(INTERFACES - 1));

    always_comb begin
        weight = cfg.interface_weights[8 * iface_reg +: 8];
        if (weight == 8'd0) begin
            weight = 8'd1;
        end
    end

    // Restoring division, DIV_BITS quotient bits per cycle.
    always_comb begin
        logic [8:0]        rext;
        logic [LOAD_W-1:0] q;
        logic [7:0]        r;
        q = load_reg;
        r = drem_reg;
        for (int j = 0; j < DIV_BITS; j++) begin
            rext = {r, q[LOAD_W-1]};
            q    = {q[LOAD_W-2:0], 1'b0};
            if (rext >= {1'b0, weight}) begin
                rext = rext - {1'b0, weight};
                q[0] = 1'b1;
            end
            r = rext[7:0];
        end
        quot_next = q;
        drem_next = r;
    end

    assign key_hit = rd_data_reg.valid && (rd_data_reg.key == job_reg.key);

    assign rd_addr = base_reg + AW'(way_reg);
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (state_reg == B_CLR) begin
            wr_en = 1'b1;
        end else if (state_reg == B_INS && free_found_reg) begin
            wr_en          = 1'b1;
            wr_addr        = base_reg + AW'(free_way_reg);
            wr_data.valid  = 1'b1;
            wr_data.choice = sel_reg;
            wr_data.key    = job_reg.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            flow_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= flow_mem[rd_addr];
    end

    // Control path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLR;
            clr_addr_reg <= '0;
            rr_pos_reg   <= 32'd0;
            rr_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < INTERFACES; i++) begin
                sess_reg[i] <= '0;
            end
        end else begin
            if (state_reg == B_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(TABLE_ENTRIES - 1)) begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (pop_valid) begin
                        state_reg <= pop_job.not_ipv4 ? B_DONE : B_RD;
                    end
                end
                B_RD: state_reg <= B_CMP;
                B_CMP: begin
                    if (key_hit) begin
                        state_reg <= B_DONE;
                    end else if (way_reg == WCW'(BUCKET_WAYS - 1)) begin
                        state_reg <= B_PICK;
                    end else begin
                        state_reg <= B_RD;
                    end
                end
                B_PICK: begin
                    case (cfg.lb_mode)
                        MODE_HASH: state_reg <= B_INS;
                        MODE_RR:   state_reg <= any_elig ? B_RR : B_INS;
                        default:   state_reg <= B_LOAD;
                    endcase
                end
                B_RR: begin
                    rr_pos_reg <= rr_pos_reg + 32'd1;
                    if (rr_pos_reg == 32'hffff_ffff ||
                        rr_idx_reg == IW'(INTERFACES - 1)) begin
                        rr_idx_reg <= '0;
                    end else begin
                        rr_idx_reg <= rr_idx_reg + 1'b1;
                    end
                    if (elig[rr_idx_reg]) begin
                        state_reg <= B_INS;
                    end
                end
                B_LOAD: begin
                    if (!elig[iface_reg]) begin
                        state_reg <= last_iface ? B_INS : B_LOAD;
                    end else if (cfg.lb_mode == MODE_WEIGHTED) begin
                        state_reg <= B_DIV;
                    end else begin
                        state_reg <= B_MIN;
                    end
                end
                B_DIV: begin
                    if (dstep_reg == 2'(DIV_STEPS - 1)) begin
                        state_reg <= B_MIN;
                    end
                end
                B_MIN: state_reg <= last_iface ? B_INS : B_LOAD;
                B_INS: begin
                    if (free_found_reg && sess_reg[sel_reg[IW-1:0]] != SESS_MAX) begin
                        sess_reg[sel_reg[IW-1:0]] <= sess_reg[sel_reg[IW-1:0]] + 1'b1;
                    end
                    state_reg <= B_DONE;
                end
                B_DONE: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Data path
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    job_reg        <= pop_job;
                    base_reg       <= pop_base;
                    way_reg        <= '0;
                    free_found_reg <= 1'b0;
                    sel_reg        <= 3'd0;
                    new_reg        <= 1'b0;
                    rec_reg        <= 1'b0;
                    nip_reg        <= pop_job.not_ipv4;
                end
            end
            B_CMP: begin
                if (key_hit) begin
                    sel_reg <= rd_data_reg.choice;
                end else begin
                    if (!rd_data_reg.valid && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_way_reg   <= way_reg;
                    end
                    way_reg <= way_reg + 1'b1;
                end
            end
            B_PICK: begin
                new_reg        <= 1'b1;
                iface_reg      <= '0;
                best_reg       <= '0;
                best_found_reg <= 1'b0;
                if (cfg.lb_mode == MODE_HASH) begin
                    sel_reg <= any_elig ? hash_sel : 3'd0;
                end else begin
                    sel_reg <= 3'd0;
                end
            end
            B_RR: begin
                if (elig[rr_idx_reg]) begin
                    sel_reg <= 3'(rr_idx_reg);
                end
            end
            B_LOAD: begin
                drem_reg  <= 8'd0;
                dstep_reg <= 2'd0;
                if (cfg.lb_mode == MODE_WEIGHTED) begin
                    load_reg <= LOAD_W'(sess_reg[iface_reg]) * LOAD_W'(LOAD_SCALE);
                end else begin
                    load_reg <= LOAD_W'(sess_reg[iface_reg]);
                end
                if (!elig[iface_reg]) begin
                    if (last_iface) begin
                        sel_reg <= 3'(best_reg);
                    end else begin
                        iface_reg <= iface_reg + 1'b1;
                    end
                end
            end
            B_DIV: begin
                load_reg  <= quot_next;
                drem_reg  <= drem_next;
                dstep_reg <= dstep_reg + 2'd1;
            end
            B_MIN: begin
                if (!best_found_reg || load_reg < min_reg) begin
                    best_found_reg <= 1'b1;
                    best_reg       <= iface_reg;
                    min_reg        <= load_reg;
                end
                if (last_iface) begin
                    sel_reg <= (!best_found_reg || load_reg < min_reg) ?
                               3'(iface_reg) : 3'(best_reg);
                end else begin
                    iface_reg <= iface_reg + 1'b1;
                end
            end
            B_INS: rec_reg <= free_found_reg;
            B_DONE: begin
                if (out_free) begin
                    m_egress_reg <= sel_reg;
                    m_flags_reg  <= {nip_reg, rec_reg, new_reg};
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/flow_affinity_load_balancer_top.sv -----
// Top level of the flow-affinity load balancer: config registers, front, queue, back.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid/s_tready    s_tdata: key fields, s_tuser: frame type
//  m_       out        m_tvalid/m_tready    m_tdata: egress_interface, m_tuser: flags
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  The front end takes an IPv4 header through the accepting cycle, the lookup3
//  lines, the reduction of the hash to a bucket and a hash pick, and a queue
//  push; others skip to the push. No new header enters until the push is done.
//  The back end reads each bucket way in turn on the single table read port,
//  then for a weighted choice loads, divides and compares each interface, and
//  overlaps the front. After reset every session table entry is swept clear;
//  no request is taken until then. A stalled result sits in the output register
//  while the front end keeps accepting until the queue is full.
module flow_affinity_load_balancer_top
    import fal_pkg::*;
#(
    parameter int INTERFACES    = 4,
    parameter int TABLE_ENTRIES = 1024,
    parameter int BUCKET_WAYS   = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // source_address, destination_address, ip_protocol, source_port, destination_port
    input  logic [103:0] s_tdata,
    // frame type
    input  logic [15:0]  s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // egress_interface, zero padding
    output logic [7:0]   m_tdata,
    // new_flow, flow_recorded, not_ipv4
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int QW = AW + $bits(job_t);

    cfg_t          cfg_reg;
    logic          clearing;
    logic          push_valid, push_ready, pop_valid, pop_ready;
    job_t          push_job, pop_job;
    logic [AW-1:0] push_base, pop_base;
    logic [QW-1:0] q_out;

    assign cfg_ready = 1'b1;

    // Register writes land at once; unknown indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lb_mode           <= RST_LB_MODE;
            cfg_reg.enabled_mask      <= RST_ENABLED;
            cfg_reg.healthy_mask      <= RST_HEALTHY;
            cfg_reg.interface_weights <= RST_WEIGHTS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LB_MODE:      cfg_reg.lb_mode           <= cfg_data[1:0];
                CFG_ENABLED_MASK: cfg_reg.enabled_mask      <= cfg_data[7:0];
                CFG_HEALTHY_MASK: cfg_reg.healthy_mask      <= cfg_data[7:0];
                CFG_WEIGHTS:      cfg_reg.interface_weights <= cfg_data;
                default: ;
            endcase
        end
    end

    fal_front #(
        .INTERFACES   (INTERFACES),
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .BUCKET_WAYS  (BUCKET_WAYS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hold      (clearing),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .push_base (push_base)
    );

    // Hold classified requests between the two halves.
    fal_fifo #(
        .WIDTH(QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data ({push_base, push_job}),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (q_out)
    );

    assign pop_base = q_out[QW-1 -: AW];
    assign pop_job  = q_out[$bits(job_t)-1:0];

    fal_back #(
        .INTERFACES   (INTERFACES),
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .BUCKET_WAYS  (BUCKET_WAYS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_job  (pop_job),
        .pop_base (pop_base),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/core/fal_checker.sv -----
// Port-level checks for the flow-affinity load balancer, bound to the top level.
module fal_checker #(
    parameter int INTERFACES = 4
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser
);

    // Non-IPv4 results go to interface zero and carry no flow flags.
    a_not_ipv4: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[2:0] == 3'd0 && m_tuser[1:0] == 2'b00)
        else $error("non-IPv4 result with interface or flow flags");

    // Only a fresh choice can be recorded.
    a_rec_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("flow recorded without new flow");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {29'd0, m_tdata[2:0]} < INTERFACES)
        else $error("egress interface out of range");

    // The table sweep blocks input right after reset.
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted during table clear");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind flow_affinity_load_balancer_top fal_checker #(
    .INTERFACES(INTERFACES)
) u_fal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// ----- verif/flow_affinity_load_balancer_top_test.sv -----
// Self-checking testbench for the flow-affinity load balancer top level.
module flow_affinity_load_balancer_top_test;
    import fal_pkg::*;

    localparam int NIF      = 4;
    localparam int ENTRIES  = 1024;
    localparam int WAYS     = 4;
    localparam int BUCKETS  = ENTRIES / WAYS;
    localparam int RANDOM_REQS = 550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [15:0]  s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [63:0]  cfg_data;

    flow_affinity_load_balancer_top #(
        .INTERFACES(NIF), .TABLE_ENTRIES(ENTRIES), .BUCKET_WAYS(WAYS)
    ) u_dut (.*);

    typedef struct packed {
        logic [15:0] frame_type;
        flow_key_t   key;
    } header_t;

    typedef struct packed {
        logic [2:0] egress;
        logic       new_flow;
        logic       recorded;
        logic       not_ipv4;
    } route_t;

    // Directed row: header plus an optional hand-typed expectation.
    typedef struct packed {
        header_t hdr;
        logic    has_route;
        route_t  route;
    } directed_row_t;

    // Shadow of the block state.
    logic [1:0]  mode_q;
    logic [7:0]  enabled_q;
    logic [7:0]  healthy_q;
    logic [63:0] weights_q;
    flow_key_t   flow_key   [ENTRIES];
    logic [2:0]  flow_choice[ENTRIES];
    logic        flow_live  [ENTRIES];
    int unsigned sessions   [NIF];
    logic [31:0] rr_position;

    route_t  pending_routes[$];
    header_t recent_flows[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    bit      send_busy = 0;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] rot(logic [31:0] x, int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] five_tuple_hash(flow_key_t k);
        logic [31:0] a, b, c;
        a = 32'hdeadbeef + 32'd16;
        b = a;
        c = a;
        a += k.source_address;
        b += k.destination_address;
        c += {k.source_port, k.destination_port};
        a -= c; a ^= rot(c, 4);  c += b;
        b -= a; b ^= rot(a, 6);  a += c;
        c -= b; c ^= rot(b, 8);  b += a;
        a -= c; a ^= rot(c, 16); c += b;
        b -= a; b ^= rot(a, 19); a += c;
        c -= b; c ^= rot(b, 4);  b += a;
        a += {24'd0, k.ip_protocol};
        c ^= b; c -= rot(b, 14);
        a ^= c; a -= rot(c, 11);
        b ^= a; b -= rot(a, 25);
        c ^= b; c -= rot(b, 16);
        a ^= c; a -= rot(c, 4);
        b ^= a; b -= rot(a, 14);
        c ^= b; c -= rot(b, 24);
        return c;
    endfunction

    function automatic bit usable(int i);
        return enabled_q[i] && healthy_q[i];
    endfunction

    // Route one header and update the shadow table, counts and position.
    function automatic route_t route_header(header_t h);
        route_t      r;
        flow_key_t   k;
        logic [31:0] hv;
        int          base, free_slot, n, target, cur, sel;
        longint      load, lowest, w;
        bit          any;
        r = '0;
        if (h.frame_type != ETH_TYPE_IPV4) begin
            r.not_ipv4 = 1'b1;
            return r;
        end
        k = h.key;
        if (k.ip_protocol != PROTO_TCP && k.ip_protocol != PROTO_UDP) begin
            k.source_port = '0;
            k.destination_port = '0;
        end
        hv = five_tuple_hash(k);
        base = (hv % BUCKETS) * WAYS;
        free_slot = -1;
        for (int j = 0; j < WAYS; j++) begin
            if (flow_live[base + j]) begin
                if (flow_key[base + j] == k) begin
                    r.egress = flow_choice[base + j];
                    return r;
                end
            end else if (free_slot < 0) begin
                free_slot = base + j;
            end
        end
        sel = 0;
        case (mode_q)
            MODE_HASH: begin
                n = 0;
                for (int i = 0; i < NIF; i++) if (usable(i)) n++;
                if (n > 0) begin
                    target = hv % n;
                    cur = 0;
                    for (int i = 0; i < NIF; i++) begin
                        if (usable(i)) begin
                            if (cur == target) sel = i;
                            cur++;
                        end
                    end
                end
            end
            MODE_RR: begin
                any = 0;
                for (int i = 0; i < NIF; i++) if (usable(i)) any = 1;
                if (any) begin
                    for (int t = 0; t < 4 * NIF; t++) begin
                        n = rr_position % NIF;
                        rr_position++;
                        if (usable(n)) begin
                            sel = n;
                            break;
                        end
                    end
                end
            end
            default: begin
                lowest = -1;
                for (int i = 0; i < NIF; i++) begin
                    if (!usable(i)) continue;
                    load = sessions[i];
                    if (mode_q == MODE_WEIGHTED) begin
                        w = weights_q[8*i +: 8];
                        if (w == 0) w = 1;
                        load = (load * 100) / w;
                    end
                    if (lowest < 0 || load < lowest) begin
                        lowest = load;
                        sel = i;
                    end
                end
            end
        endcase
        r.egress = sel[2:0];
        r.new_flow = 1'b1;
        if (free_slot >= 0) begin
            flow_key[free_slot] = k;
            flow_choice[free_slot] = sel[2:0];
            flow_live[free_slot] = 1'b1;
            if (sessions[sel] < SESS_MAX) sessions[sel]++;
            r.recorded = 1'b1;
        end
        return r;
    endfunction

    // Hold each request until taken; predict at acceptance.
    task automatic send_request(header_t h, bit has_route, route_t fixed);
        route_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {h.key.destination_port, h.key.source_port, h.key.ip_protocol,
                     h.key.destination_address, h.key.source_address};
        s_tuser  <= h.frame_type;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = route_header(h);
        if (has_route && r != fixed) begin
            $display("%0t: directed row disagrees with prediction: %h vs %h",
                     $time, fixed, r);
            fail_count++;
        end
        pending_routes.push_back(r);
        if (h.frame_type == ETH_TYPE_IPV4 && recent_flows.size() < 64)
            recent_flows.push_back(h);
    endtask

    task automatic idle_sender(int gap);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    // Wait for the pipeline to drain, then write one register.
    task automatic write_register(logic [7:0] idx, logic [63:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LB_MODE:      mode_q    = value[1:0];
            CFG_ENABLED_MASK: enabled_q = value[7:0];
            CFG_HEALTHY_MASK: healthy_q = value[7:0];
            CFG_WEIGHTS:      weights_q = value;
            default: ;
        endcase
    endtask

    function automatic header_t random_header();
        header_t h;
        h.key = 104'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 9))
            0: h.frame_type = 16'($urandom_range(0, 16'hffff));
            default: h.frame_type = ETH_TYPE_IPV4;
        endcase
        case ($urandom_range(0, 3))
            0: h.key.ip_protocol = PROTO_TCP;
            1: h.key.ip_protocol = PROTO_UDP;
            2: h.key.ip_protocol = 8'($urandom_range(0, 255));
            default: h.key.ip_protocol = $urandom_range(0, 1) ? 8'd1 : 8'd255;
        endcase
        // Reuse an earlier IPv4 header now and then to exercise table hits.
        if (recent_flows.size() > 0 && $urandom_range(0, 3) == 0)
            h = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
        return h;
    endfunction

    // Receiver: stall on its own pattern, compare against the oldest prediction.
    initial begin
        route_t got, want;
        int     phase;
        m_tready = 1'b0;
        phase = 0;
        @(posedge aclk);
        forever begin
            phase++;
            if ((phase / 200) % 3 == 2) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tuser[0], m_tuser[1], m_tuser[2]};
                if (pending_routes.size() == 0) begin
                    $display("%0t: unexpected result, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = pending_routes.pop_front();
                    if (got.egress !== want.egress)
                        $display("%0t: egress_interface expected %0d got %0d",
                                 $time, want.egress, got.egress);
                    if (got.new_flow !== want.new_flow)
                        $display("%0t: new_flow expected %0b got %0b",
                                 $time, want.new_flow, got.new_flow);
                    if (got.recorded !== want.recorded)
                        $display("%0t: flow_recorded expected %0b got %0b",
                                 $time, want.recorded, got.recorded);
                    if (got.not_ipv4 !== want.not_ipv4)
                        $display("%0t: not_ipv4 expected %0b got %0b",
                                 $time, want.not_ipv4, got.not_ipv4);
                    if (got !== want) fail_count++;
                end
            end
        end
    end

    directed_row_t directed[$];

    initial begin
        header_t h;
        route_t  none;
        int      burst;
        none = '0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        mode_q = RST_LB_MODE;
        enabled_q = RST_ENABLED;
        healthy_q = RST_HEALTHY;
        weights_q = RST_WEIGHTS;
        for (int i = 0; i < ENTRIES; i++) flow_live[i] = 1'b0;
        for (int i = 0; i < NIF; i++) sessions[i] = 0;
        rr_position = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: non-IPv4 extremes, protocol extremes, repeats of one flow.
        directed.push_back('{'{16'h0000, '0}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b1}});
        directed.push_back('{'{16'hffff, '1}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b1}});
        directed.push_back('{'{16'h0801, '0}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b1}});
        directed.push_back('{'{ETH_TYPE_IPV4, '0}, 1'b0, none});
        directed.push_back('{'{ETH_TYPE_IPV4, '0}, 1'b0, none});
        directed.push_back('{'{ETH_TYPE_IPV4, '1}, 1'b0, none});
        directed.push_back('{'{ETH_TYPE_IPV4, {32'h0a000001, 32'h0a000002, PROTO_TCP,
                                               16'd80, 16'd1234}}, 1'b0, none});
        directed.push_back('{'{ETH_TYPE_IPV4, {32'h0a000001, 32'h0a000002, PROTO_UDP,
                                               16'hffff, 16'h0000}}, 1'b0, none});
        // Ports are ignored for other protocols: these two share one key.
        directed.push_back('{'{ETH_TYPE_IPV4, {32'h0a000001, 32'h0a000002, 8'd1,
                                               16'd5, 16'd6}}, 1'b0, none});
        directed.push_back('{'{ETH_TYPE_IPV4, {32'h0a000001, 32'h0a000002, 8'd1,
                                               16'd9, 16'd9}}, 1'b0, none});
        directed.push_back('{'{ETH_TYPE_IPV4, {32'h0a000001, 32'h0a000002, PROTO_TCP,
                                               16'd80, 16'd1234}}, 1'b0, none});
        foreach (directed[i])
            send_request(directed[i].hdr, directed[i].has_route, directed[i].route);

        // Walk all modes, also with no usable interface.
        for (int m = 0; m < 4; m++) begin
            write_register(CFG_LB_MODE, 64'(m));
            for (int j = 0; j < 3; j++) send_request(random_header(), 1'b0, none);
        end
        write_register(CFG_HEALTHY_MASK, 64'h00);
        for (int m = 0; m < 4; m++) begin
            write_register(CFG_LB_MODE, 64'(m));
            send_request(random_header(), 1'b0, none);
        end
        write_register(8'd7, 64'h3);            // out of range, ignored
        write_register(CFG_HEALTHY_MASK, 64'hff);
        write_register(CFG_ENABLED_MASK, 64'h00);
        send_request(random_header(), 1'b0, none);
        write_register(CFG_ENABLED_MASK, 64'hff);
        write_register(CFG_WEIGHTS, 64'h0);
        send_request(random_header(), 1'b0, none);
        write_register(CFG_WEIGHTS, '1);
        send_request(random_header(), 1'b0, none);

        // Random phases: new settings between bursts of traffic.
        for (int p = 0; p < 10; p++) begin
            write_register(CFG_LB_MODE, 64'($urandom_range(0, 3)));
            write_register(CFG_ENABLED_MASK, 64'($urandom_range(0, 255)));
            write_register(CFG_HEALTHY_MASK, 64'($urandom_range(1, 255)) | 64'h1);
            write_register(CFG_WEIGHTS, {$urandom, $urandom});
            for (int n = 0; n < RANDOM_REQS / 10;) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < RANDOM_REQS / 10; b++, n++) begin
                    h = random_header();
                    send_request(h, 1'b0, none);
                end
                if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
            end
        end

        s_tvalid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/fal_pkg.sv
rtl/core/fal_front.sv
rtl/core/fal_fifo.sv
rtl/core/fal_back.sv
rtl/core/flow_affinity_load_balancer_top.sv
rtl/core/fal_checker.sv
verif/flow_affinity_load_balancer_top_test.sv
